>>> hw/rtl/ppm_pkg.sv
`default_nettype none

package ppm_pkg;

	// Field widths
	localparam int unsigned CountW = 32;
	localparam int unsigned SumW   = 40;
	localparam int unsigned BitsW  = 32;
	localparam int unsigned SeenW  = 17;
	localparam int unsigned PosW   = 33;

	// Configuration register indexes
	localparam logic [1:0] CFG_SCALAR_TYPE    = 2'd0;
	localparam logic [1:0] CFG_ELEMENT_COUNT  = 2'd1;
	localparam logic [1:0] CFG_ELEMENT_OFFSET = 2'd2;

	// Compare modes (code 3 compares as unsigned)
	localparam logic [1:0] SCALAR_UNSIGNED = 2'd0;
	localparam logic [1:0] SCALAR_SIGNED   = 2'd1;
	localparam logic [1:0] SCALAR_FLOAT    = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	// One probe record, last field in the lowest bits
	typedef struct packed {
		logic [BitsW-1:0]  hit_bits;
		logic [BitsW-1:0]  hit_index;
		logic [BitsW-1:0]  high_bits;
		logic [BitsW-1:0]  low_bits;
		logic [CountW-1:0] inf_count;
		logic [CountW-1:0] nan_count;
		logic [CountW-1:0] match_count;
		logic [CountW-1:0] finite_count;
	} rec_t;

	// Accumulated totals of a closed set
	typedef struct packed {
		logic [SumW-1:0]  sum_finite;
		logic [SumW-1:0]  sum_matched;
		logic [SumW-1:0]  sum_nan;
		logic [SumW-1:0]  sum_inf;
		logic             have_extrema;
		logic [BitsW-1:0] best_low;
		logic [BitsW-1:0] best_high;
		logic [BitsW-1:0] best_hit_index;
		logic [BitsW-1:0] best_hit_bits;
		logic             too_many;
	} acc_t;

	// Summary item, last field in the lowest bits
	typedef struct packed {
		logic [2:0]       pad;
		logic [1:0]       status;
		logic [BitsW-1:0] first_value_bits;
		logic [PosW-1:0]  first_position;
		logic             first_valid;
		logic [BitsW-1:0] max_value_bits;
		logic [BitsW-1:0] min_value_bits;
		logic             extrema_valid;
		logic [SumW-1:0]  total_inf;
		logic [SumW-1:0]  total_nan;
		logic [SumW-1:0]  total_matched;
		logic [SumW-1:0]  total_finite;
	} res_t;

	// Saturating add of a record count into a running sum
	function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
		input logic [CountW-1:0] b);
		logic [SumW:0] s;
		s = {1'b0, a} + {{(SumW+1-CountW){1'b0}}, b};
		return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
	endfunction

	function automatic logic is_nan(input logic [BitsW-1:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	// True when a orders strictly before b in the given mode
	function automatic logic less_than(input logic [1:0] mode,
		input logic [BitsW-1:0] a, input logic [BitsW-1:0] b);
		logic [BitsW-1:0] ka;
		logic [BitsW-1:0] kb;
		logic             res;
		ka = a[31] ? ~a : (a | 32'h8000_0000);
		kb = b[31] ? ~b : (b | 32'h8000_0000);
		case (mode)
			SCALAR_SIGNED: res = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
			SCALAR_FLOAT: begin
				if (is_nan(a) || is_nan(b))
					res = 1'b0;
				else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
					res = 1'b0;
				else
					res = ka < kb;
			end
			default: res = a < b;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/probe_partial_merge.sv
`default_nettype none

// Merges per-workgroup probe records into one summary. One record is taken
// per clock, back to back, unless a closing record waits on a stalled check
// stage; the record goes through an input register, then a single accumulate
// stage (saturating count sums, min/max compare, smallest first index) closes
// the feedback loop. A record with tlast set closes the set: its totals move to
// a check stage that derives the status and first position, and the summary
// reaches the master side through an output register. Accumulation restarts
// from clear state with the following record, so sets may follow without a gap.
// Configuration must only be written while no record is in flight.
module probe_partial_merge #(
	parameter int unsigned MAX_RECORDS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [39:0]  cfg_data,
	// Records in
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// finite_count, match_count, nan_count, inf_count, low_bits, high_bits,
	// hit_index, hit_bits (32 bits each, lowest first)
	input  wire logic [255:0] s_tdata,
	input  wire logic         s_tlast,   // final_record
	// Summary out
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// total_finite, total_matched, total_nan, total_inf (40 each), extrema_valid,
	// min_value_bits, max_value_bits (32 each), first_valid, first_position (33),
	// first_value_bits (32), status (2), zero pad (3); lowest first
	output logic [295:0]      m_tdata
);

	localparam logic [ppm_pkg::SeenW-1:0] MaxRec = ppm_pkg::SeenW'(MAX_RECORDS);

	// Configuration registers
	logic [1:0]                 scalar_type_q;
	logic [ppm_pkg::SumW-1:0]   element_count_q;
	logic [ppm_pkg::BitsW-1:0]  element_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scalar_type_q    <= ppm_pkg::SCALAR_UNSIGNED;
			element_count_q  <= '0;
			element_offset_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ppm_pkg::CFG_SCALAR_TYPE:    scalar_type_q    <= cfg_data[1:0];
				ppm_pkg::CFG_ELEMENT_COUNT:  element_count_q  <= cfg_data;
				ppm_pkg::CFG_ELEMENT_OFFSET: element_offset_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	logic          vld_s1, vld_s2, vld_s3;
	ppm_pkg::rec_t rec_s1;
	logic          last_s1;
	ppm_pkg::acc_t acc_s2;
	ppm_pkg::res_t res_s3;
	logic          take_s3, take_s2, take_s1;

	assign take_s3  = !vld_s3 || m_tready;
	assign take_s2  = !vld_s2 || take_s3;
	assign take_s1  = vld_s1 && (!last_s1 || take_s2);
	assign s_tready = !vld_s1 || take_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rec_s1  <= ppm_pkg::rec_t'(s_tdata);
			last_s1 <= s_tlast;
		end
	end

	// Accumulation state
	logic [ppm_pkg::SumW-1:0]  sum_finite_q, sum_matched_q, sum_nan_q, sum_inf_q;
	logic                      have_q;
	logic [ppm_pkg::BitsW-1:0] best_low_q, best_high_q, best_idx_q, best_bits_q;
	logic [ppm_pkg::SeenW-1:0] seen_q;

	ppm_pkg::acc_t             acc_d;
	logic [ppm_pkg::SeenW-1:0] seen_d;
	logic                      has_finite;

	// Fold the registered record into the running state
	always_comb begin
		has_finite = rec_s1.finite_count != '0;
		acc_d.sum_finite  = ppm_pkg::sat_add(sum_finite_q, rec_s1.finite_count);
		acc_d.sum_matched = ppm_pkg::sat_add(sum_matched_q, rec_s1.match_count);
		acc_d.sum_nan     = ppm_pkg::sat_add(sum_nan_q, rec_s1.nan_count);
		acc_d.sum_inf     = ppm_pkg::sat_add(sum_inf_q, rec_s1.inf_count);
		acc_d.have_extrema = have_q || has_finite;
		acc_d.best_low     = best_low_q;
		acc_d.best_high    = best_high_q;
		if (has_finite) begin
			if (!have_q || ppm_pkg::less_than(scalar_type_q, rec_s1.low_bits, best_low_q))
				acc_d.best_low = rec_s1.low_bits;
			if (!have_q || ppm_pkg::less_than(scalar_type_q, best_high_q, rec_s1.high_bits))
				acc_d.best_high = rec_s1.high_bits;
		end
		if (rec_s1.hit_index < best_idx_q) begin
			acc_d.best_hit_index = rec_s1.hit_index;
			acc_d.best_hit_bits  = rec_s1.hit_bits;
		end else begin
			acc_d.best_hit_index = best_idx_q;
			acc_d.best_hit_bits  = best_bits_q;
		end
		seen_d = (seen_q != {ppm_pkg::SeenW{1'b1}}) ? seen_q + 1'b1 : seen_q;
		acc_d.too_many = seen_d > MaxRec;
	end

	// A closing record returns the state to clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_finite_q  <= '0;
			sum_matched_q <= '0;
			sum_nan_q     <= '0;
			sum_inf_q     <= '0;
			have_q        <= 1'b0;
			best_low_q    <= '0;
			best_high_q   <= '0;
			best_idx_q    <= '1;
			best_bits_q   <= '0;
			seen_q        <= '0;
		end else if (take_s1) begin
			if (last_s1) begin
				sum_finite_q  <= '0;
				sum_matched_q <= '0;
				sum_nan_q     <= '0;
				sum_inf_q     <= '0;
				have_q        <= 1'b0;
				best_low_q    <= '0;
				best_high_q   <= '0;
				best_idx_q    <= '1;
				best_bits_q   <= '0;
				seen_q        <= '0;
			end else begin
				sum_finite_q  <= acc_d.sum_finite;
				sum_matched_q <= acc_d.sum_matched;
				sum_nan_q     <= acc_d.sum_nan;
				sum_inf_q     <= acc_d.sum_inf;
				have_q        <= acc_d.have_extrema;
				best_low_q    <= acc_d.best_low;
				best_high_q   <= acc_d.best_high;
				best_idx_q    <= acc_d.best_hit_index;
				best_bits_q   <= acc_d.best_hit_bits;
				seen_q        <= seen_d;
			end
		end
	end

	// Closed set totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (take_s2)
			vld_s2 <= take_s1 && last_s1;
	end

	always_ff @(posedge clk) begin
		if (take_s2 && take_s1 && last_s1)
			acc_s2 <= acc_d;
	end

	// Checks and output formatting
	ppm_pkg::res_t             res_d;
	logic                      first_valid;
	logic [ppm_pkg::SumW+1:0]  covered;
	logic                      mismatch;

	always_comb begin
		first_valid = acc_s2.best_hit_index != {ppm_pkg::BitsW{1'b1}};
		covered = {2'b0, acc_s2.sum_finite} + {2'b0, acc_s2.sum_nan} + {2'b0, acc_s2.sum_inf};
		mismatch = (covered != {2'b0, element_count_q})
			|| (acc_s2.sum_matched > element_count_q)
			|| (first_valid && ({8'd0, acc_s2.best_hit_index} >= element_count_q))
			|| ((acc_s2.sum_matched == '0) == first_valid);

		res_d.pad            = '0;
		res_d.total_finite   = acc_s2.sum_finite;
		res_d.total_matched  = acc_s2.sum_matched;
		res_d.total_nan      = acc_s2.sum_nan;
		res_d.total_inf      = acc_s2.sum_inf;
		res_d.extrema_valid  = acc_s2.have_extrema;
		res_d.min_value_bits = acc_s2.have_extrema ? acc_s2.best_low : '0;
		res_d.max_value_bits = acc_s2.have_extrema ? acc_s2.best_high : '0;
		res_d.first_valid    = first_valid;
		res_d.first_position = first_valid
			? {1'b0, element_offset_q} + {1'b0, acc_s2.best_hit_index} : '0;
		res_d.first_value_bits = first_valid ? acc_s2.best_hit_bits : '0;
		if (acc_s2.too_many)
			res_d.status = ppm_pkg::STATUS_TOO_MANY;
		else if (mismatch)
			res_d.status = ppm_pkg::STATUS_MISMATCH;
		else
			res_d.status = ppm_pkg::STATUS_OK;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (take_s3)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (take_s3 && vld_s2)
			res_s3 <= res_d;
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = res_s3;

endmodule

`default_nettype wire
